[rtl/crls_pkg.sv]
// shared types and constants for the command retry link supervisor
// no dependencies; imported by command_retry_link_supervisor_top and its testbench
`default_nettype none

package crls_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int IN_DATA_W  = 96;
    localparam int OUT_DATA_W = 96;
    localparam int STOP_REPEATS = 3;

    localparam logic [15:0] RST_RETRY_INTERVAL = 16'd100;
    localparam logic [7:0]  RST_MAX_RETRIES    = 8'd3;
    localparam logic [15:0] RST_LINK_TIMEOUT   = 16'd1000;
    localparam logic [15:0] RST_HB_INTERVAL    = 16'd500;
    localparam logic [7:0]  RST_STOP_CODE      = 8'd0;

    typedef enum logic [1:0] {
        EV_TICK = 2'd0,
        EV_SEND = 2'd1,
        EV_RX   = 2'd2,
        EV_NONE = 2'd3
    } t_event;

    typedef enum logic [1:0] {
        RX_TELEMETRY = 2'd0,
        RX_ACK       = 2'd1,
        RX_OTHER     = 2'd2,
        RX_RESERVED  = 2'd3
    } t_rx_kind;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RETRY_INTERVAL = 3'd0,
        CFG_MAX_RETRIES    = 3'd1,
        CFG_LINK_TIMEOUT   = 3'd2,
        CFG_HB_INTERVAL    = 3'd3,
        CFG_STOP_CODE      = 3'd4
    } t_cfg_idx;

    localparam logic TX_KIND_CMD = 1'b0;
    localparam logic TX_KIND_HB  = 1'b1;

    typedef struct packed {
        logic        kind;
        logic [15:0] seq;
        logic [7:0]  code;
        logic [31:0] arg;
        logic [31:0] stamp;
    } t_frame;

    typedef struct packed {
        logic link_up;
        logic telemetry_fresh;
        logic gave_up;
        logic rejected;
    } t_status;

endpackage

`default_nettype wire

[rtl/command_retry_link_supervisor_top.sv]
// stop-and-wait command sender with retry, heartbeat and link supervision
// depends on crls_pkg
`default_nettype none

// usage
//  slave stream: one event per transfer (tick, new command, received frame);
//  tuser holds the event kind, tdata the event fields
//  master stream: one to three result transfers per event, tlast on the last;
//  tuser[0] set when the transfer carries a frame to send
//  config channel: register index and data, always ready, written while idle
//  an accepted event is held in the input register, then its results in the result register
//  throughput: one event per cycle when each gives one result and the receiver
//  does not stall; an event with more than one result holds the result register
//  until its last result leaves
//  the result register, not the input register, sets the pace: the input
//  register refills in the cycle the last result of the previous event leaves
//  reset clears all supervisor state and loads the default register values
//  a stalled receiver holds the current result; one more event waits in the
//  input register and then tready drops
module command_retry_link_supervisor_top #(
    parameter int SEQ_BITS = 16
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_s_axis_tvalid,
    output logic                                     o_s_axis_tready,
    // now_time[31:0] cmd_code[39:32] cmd_arg[71:40] rx_kind[73:72]
    // rx_header_ok[74] rx_length_ok[75] rx_ack_seq[91:76] rx_accepted[92]
    input  wire logic [crls_pkg::IN_DATA_W-1:0]      i_s_axis_tdata,
    // event kind[1:0]
    input  wire logic [1:0]                          i_s_axis_tuser,
    output logic                                     o_m_axis_tvalid,
    input  wire logic                                i_m_axis_tready,
    // tx_seq[15:0] tx_code[23:16] tx_arg[55:24] tx_stamp[87:56] link_up[88]
    // telemetry_fresh[89] gave_up[90] rejected[91]
    output logic [crls_pkg::OUT_DATA_W-1:0]          o_m_axis_tdata,
    // tx_valid[0] tx_kind[1]
    output logic [1:0]                               o_m_axis_tuser,
    output logic                                     o_m_axis_tlast,
    input  wire logic                                i_cfg_valid,
    output logic                                     o_cfg_ready,
    input  wire logic [crls_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire logic [crls_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import crls_pkg::*;

    localparam int AW = (SEQ_BITS > 16) ? SEQ_BITS : 16;
    localparam logic [AW-1:0] SEQ_MASK = AW'({SEQ_BITS{1'b1}});

    // configuration
    logic [15:0] r_cfg_retry;
    logic [7:0]  r_cfg_max;
    logic [15:0] r_cfg_timeout;
    logic [15:0] r_cfg_hb;
    logic [7:0]  r_cfg_stop;

    // supervisor state
    logic                r_inf_vld,   n_inf_vld;
    logic [7:0]          r_retry_cnt, n_retry_cnt;
    logic [31:0]         r_last_send, n_last_send;
    logic [31:0]         r_last_rx,   n_last_rx;
    logic [31:0]         r_telem,     n_telem;
    logic [31:0]         r_last_hb,   n_last_hb;
    logic [SEQ_BITS-1:0] r_next_seq,  n_next_seq;
    logic [SEQ_BITS-1:0] r_inf_seq,   n_inf_seq;
    logic [7:0]          r_inf_code,  n_inf_code;
    logic [31:0]         r_inf_arg,   n_inf_arg;
    logic [31:0]         r_inf_stamp, n_inf_stamp;

    // input register
    logic                 r_in_vld;
    t_event               r_in_ev;
    logic [IN_DATA_W-1:0] r_in_data;

    // result buffer
    logic        r_out_vld;
    logic [1:0]  r_cnt,  n_cnt;
    logic [1:0]  r_pos;
    logic        r_use_b, n_use_b;
    logic        r_txv,   n_txv;
    t_frame      r_fa,    n_fa;
    t_frame      r_fb,    n_fb;
    t_status     r_stat,  n_stat;

    logic [31:0] w_now;
    logic [7:0]  w_code;
    logic [31:0] w_arg;
    t_rx_kind    w_rx_kind;
    logic        w_hdr_ok;
    logic        w_len_ok;
    logic [15:0] w_ack_seq;
    logic        w_accepted;

    logic        w_out_xfer;
    logic        w_out_last;
    logic        w_buf_free;
    logic        w_proc;
    t_frame      w_frame;

    logic [AW-1:0] w_next_ext;
    logic [AW-1:0] w_inf_ext;
    logic [AW-1:0] w_ack_ext;
    logic          w_resend;
    logic          w_hb;
    logic          w_resend_due;
    logic          w_hb_due;
    t_frame        w_resend_frame;
    t_frame        w_hb_frame;

    assign w_now      = r_in_data[31:0];
    assign w_code     = r_in_data[39:32];
    assign w_arg      = r_in_data[71:40];
    assign w_rx_kind  = t_rx_kind'(r_in_data[73:72]);
    assign w_hdr_ok   = r_in_data[74];
    assign w_len_ok   = r_in_data[75];
    assign w_ack_seq  = r_in_data[91:76];
    assign w_accepted = r_in_data[92];

    assign w_out_last = (r_pos == (r_cnt - 2'd1));
    assign w_out_xfer = r_out_vld && i_m_axis_tready;
    assign w_buf_free = !r_out_vld || (w_out_xfer && w_out_last);
    assign w_proc     = r_in_vld && w_buf_free;

    assign o_s_axis_tready = !r_in_vld || w_proc;
    assign o_cfg_ready     = 1'b1;

    assign w_next_ext = AW'(r_next_seq);
    assign w_inf_ext  = AW'(r_inf_seq);
    assign w_ack_ext  = AW'(w_ack_seq) & SEQ_MASK;

    assign w_resend_due = r_inf_vld && ((w_now - r_last_send) >= {16'd0, r_cfg_retry});
    assign w_hb_due     = (w_now - r_last_hb) >= {16'd0, r_cfg_hb};

    always_comb begin
        w_resend_frame = '{kind: TX_KIND_CMD, seq: w_inf_ext[15:0], code: r_inf_code,
                           arg: r_inf_arg, stamp: r_inf_stamp};
        w_hb_frame     = '{kind: TX_KIND_HB, seq: w_next_ext[15:0], code: 8'd0,
                           arg: 32'd0, stamp: 32'd0};
    end

    always_comb begin
        n_inf_vld   = r_inf_vld;
        n_retry_cnt = r_retry_cnt;
        n_last_send = r_last_send;
        n_last_rx   = r_last_rx;
        n_telem     = r_telem;
        n_last_hb   = r_last_hb;
        n_next_seq  = r_next_seq;
        n_inf_seq   = r_inf_seq;
        n_inf_code  = r_inf_code;
        n_inf_arg   = r_inf_arg;
        n_inf_stamp = r_inf_stamp;
        n_cnt       = 2'd1;
        n_use_b     = 1'b0;
        n_txv       = 1'b0;
        n_fa        = '0;
        n_fb        = '0;
        n_stat      = '0;
        w_resend    = 1'b0;
        w_hb        = 1'b0;
        case (r_in_ev)
            EV_SEND: begin
                n_inf_seq   = r_next_seq;
                n_next_seq  = r_next_seq + SEQ_BITS'(1);
                n_inf_code  = w_code;
                n_inf_arg   = w_arg;
                n_inf_stamp = w_now;
                n_inf_vld   = 1'b1;
                n_retry_cnt = 8'd0;
                n_last_send = w_now;
                n_txv       = 1'b1;
                n_fa        = '{kind: TX_KIND_CMD, seq: w_next_ext[15:0], code: w_code,
                                arg: w_arg, stamp: w_now};
                n_cnt       = (w_code == r_cfg_stop) ? 2'(STOP_REPEATS) : 2'd1;
            end
            EV_TICK: begin
                if (w_resend_due) begin
                    if (r_retry_cnt < r_cfg_max) begin
                        n_retry_cnt = r_retry_cnt + 8'd1;
                        n_last_send = w_now;
                        w_resend    = 1'b1;
                    end else begin
                        n_inf_vld      = 1'b0;
                        n_stat.gave_up = 1'b1;
                    end
                end
                if (w_hb_due) begin
                    n_last_hb  = w_now;
                    n_next_seq = r_next_seq + SEQ_BITS'(1);
                    w_hb       = 1'b1;
                end
                if (w_resend && w_hb) begin
                    n_txv   = 1'b1;
                    n_fa    = w_resend_frame;
                    n_fb    = w_hb_frame;
                    n_cnt   = 2'd2;
                    n_use_b = 1'b1;
                end else if (w_resend) begin
                    n_txv = 1'b1;
                    n_fa  = w_resend_frame;
                end else if (w_hb) begin
                    n_txv = 1'b1;
                    n_fa  = w_hb_frame;
                end
            end
            EV_RX: begin
                if (w_hdr_ok) begin
                    n_last_rx = w_now;
                    if (w_rx_kind == RX_TELEMETRY && w_len_ok) begin
                        n_telem = w_now;
                    end else if (w_rx_kind == RX_ACK && w_len_ok) begin
                        if (r_inf_vld && (w_ack_ext == w_inf_ext)) begin
                            n_inf_vld       = 1'b0;
                            n_stat.rejected = !w_accepted;
                        end
                    end
                end
            end
            default: begin
            end
        endcase
        n_stat.link_up         = (n_last_rx != 32'd0) &&
                                 ((w_now - n_last_rx) < {16'd0, r_cfg_timeout});
        n_stat.telemetry_fresh = (n_telem != 32'd0) &&
                                 ((w_now - n_telem) < {16'd0, r_cfg_timeout});
    end

    // config writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_retry   <= RST_RETRY_INTERVAL;
            r_cfg_max     <= RST_MAX_RETRIES;
            r_cfg_timeout <= RST_LINK_TIMEOUT;
            r_cfg_hb      <= RST_HB_INTERVAL;
            r_cfg_stop    <= RST_STOP_CODE;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_RETRY_INTERVAL: r_cfg_retry   <= i_cfg_data;
                CFG_MAX_RETRIES:    r_cfg_max     <= i_cfg_data[7:0];
                CFG_LINK_TIMEOUT:   r_cfg_timeout <= i_cfg_data;
                CFG_HB_INTERVAL:    r_cfg_hb      <= i_cfg_data;
                CFG_STOP_CODE:      r_cfg_stop    <= i_cfg_data[7:0];
                default: begin
                end
            endcase
        end
    end

    // supervisor state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inf_vld   <= 1'b0;
            r_retry_cnt <= '0;
            r_last_send <= '0;
            r_last_rx   <= '0;
            r_telem     <= '0;
            r_last_hb   <= '0;
            r_next_seq  <= '0;
            r_inf_seq   <= '0;
            r_inf_code  <= '0;
            r_inf_arg   <= '0;
            r_inf_stamp <= '0;
        end else if (w_proc) begin
            r_inf_vld   <= n_inf_vld;
            r_retry_cnt <= n_retry_cnt;
            r_last_send <= n_last_send;
            r_last_rx   <= n_last_rx;
            r_telem     <= n_telem;
            r_last_hb   <= n_last_hb;
            r_next_seq  <= n_next_seq;
            r_inf_seq   <= n_inf_seq;
            r_inf_code  <= n_inf_code;
            r_inf_arg   <= n_inf_arg;
            r_inf_stamp <= n_inf_stamp;
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (i_s_axis_tvalid && o_s_axis_tready) begin
            r_in_vld <= 1'b1;
        end else if (w_proc) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_s_axis_tvalid && o_s_axis_tready) begin
            r_in_ev   <= t_event'(i_s_axis_tuser);
            r_in_data <= i_s_axis_tdata;
        end
    end

    // result buffer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
            r_pos     <= '0;
            r_cnt     <= 2'd1;
        end else if (w_proc) begin
            r_out_vld <= 1'b1;
            r_pos     <= '0;
            r_cnt     <= n_cnt;
        end else if (w_out_xfer) begin
            if (w_out_last) begin
                r_out_vld <= 1'b0;
            end else begin
                r_pos <= r_pos + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_proc) begin
            r_use_b <= n_use_b;
            r_txv   <= n_txv;
            r_fa    <= n_fa;
            r_fb    <= n_fb;
            r_stat  <= n_stat;
        end
    end

    assign w_frame = ((r_pos != 2'd0) && r_use_b) ? r_fb : r_fa;

    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tlast  = w_out_last;
    assign o_m_axis_tuser  = {w_frame.kind, r_txv};
    assign o_m_axis_tdata  = {4'd0, r_stat.rejected, r_stat.gave_up,
                              r_stat.telemetry_fresh, r_stat.link_up,
                              w_frame.stamp, w_frame.arg, w_frame.code, w_frame.seq};

    // checks
    a_pos_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld |-> (r_pos < r_cnt))
        else $error("result position beyond result count");

    a_status_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld |-> !(r_stat.gave_up && r_stat.rejected))
        else $error("gave_up and rejected raised together");

    a_idle_item_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && !r_txv) |-> o_m_axis_tlast)
        else $error("status-only result not marked last");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> (!r_out_vld && !r_in_vld))
        else $error("buffers not empty after reset");

endmodule

`default_nettype wire

[tb/tb_command_retry_link_supervisor_top.sv]
// self-checking testbench for command_retry_link_supervisor_top: events go in through
// a stream driver, results are checked against a cycle-free model of the sender state
// depends on crls_pkg and command_retry_link_supervisor_top
`timescale 1ns / 1ps

module tb_command_retry_link_supervisor_top;
    import crls_pkg::*;

    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int DRAIN_CYCLES    = 8;
    localparam int PHASES          = 6;
    localparam int ITEMS_PER_PHASE = 50;

    localparam logic [1:0] SINK_FREE     = 2'd0;
    localparam logic [1:0] SINK_RANDOM   = 2'd1;
    localparam logic [1:0] SINK_PERIODIC = 2'd2;

    typedef struct {
        t_event      ev;
        logic [31:0] now;
        logic [7:0]  code;
        logic [31:0] arg;
        t_rx_kind    rx_kind;
        logic        hdr_ok;
        logic        len_ok;
        logic [15:0] ack_seq;
        logic        accepted;
        logic        live_ack;
    } t_link_event;

    typedef struct {
        logic        tx_valid;
        logic        tx_kind;
        logic [15:0] seq;
        logic [7:0]  code;
        logic [31:0] arg;
        logic [31:0] stamp;
        logic        last;
        logic        link_up;
        logic        telem_fresh;
        logic        gave_up;
        logic        rejected;
    } t_link_result;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata = '0;
    logic [1:0]            s_tuser = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic [1:0]            m_tuser;
    logic                  m_tlast;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    command_retry_link_supervisor_top #(
        .SEQ_BITS(16)
    ) uut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_s_axis_tvalid(s_tvalid),
        .o_s_axis_tready(s_tready),
        .i_s_axis_tdata (s_tdata),
        .i_s_axis_tuser (s_tuser),
        .o_m_axis_tvalid(m_tvalid),
        .i_m_axis_tready(m_tready),
        .o_m_axis_tdata (m_tdata),
        .o_m_axis_tuser (m_tuser),
        .o_m_axis_tlast (m_tlast),
        .i_cfg_valid    (cfg_valid),
        .o_cfg_ready    (cfg_ready),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data)
    );

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // register copies
    logic [15:0] retry_gap_ms = RST_RETRY_INTERVAL;
    logic [7:0]  retry_limit  = RST_MAX_RETRIES;
    logic [15:0] stale_ms     = RST_LINK_TIMEOUT;
    logic [15:0] beat_gap_ms  = RST_HB_INTERVAL;
    logic [7:0]  stop_cmd     = RST_STOP_CODE;

    // sender state
    logic        cur_inflight = 1'b0;
    logic [7:0]  cur_retries  = '0;
    logic [31:0] sent_at      = '0;
    logic [31:0] heard_at     = '0;
    logic [31:0] telem_at     = '0;
    logic [31:0] beat_at      = '0;
    logic [15:0] seq_next     = '0;
    logic [15:0] cur_seq      = '0;
    logic [7:0]  cur_code     = '0;
    logic [31:0] cur_arg      = '0;
    logic [31:0] cur_stamp    = '0;

    t_link_event  events_pending[$];
    t_link_result frames_due[$];
    t_link_event  on_wire;
    t_link_result want;
    t_link_result seen;

    logic [31:0] gen_now = '0;
    logic        in_fire = 1'b0;
    int          gap_left = 0;
    int          burst_left = 0;
    logic [1:0]  sink_mode = SINK_FREE;
    int          sink_left = 0;
    int          sink_period = 2;
    int          sink_step = 0;
    int          quiet_cycles = 0;
    int          err_cnt = 0;
    int          queued_events = 0;
    int          events_in = 0;
    int          results_out = 0;
    int          frames_out = 0;
    int          drops_seen = 0;
    int          rejects_seen = 0;
    int          cfg_writes = 0;

    function automatic t_link_result make_frame(input logic valid, input logic kind,
                                                input logic [15:0] seq,
                                                input logic [7:0] code,
                                                input logic [31:0] arg,
                                                input logic [31:0] stamp);
        t_link_result r;
        r.tx_valid    = valid;
        r.tx_kind     = kind;
        r.seq         = seq;
        r.code        = code;
        r.arg         = arg;
        r.stamp       = stamp;
        r.last        = 1'b0;
        r.link_up     = 1'b0;
        r.telem_fresh = 1'b0;
        r.gave_up     = 1'b0;
        r.rejected    = 1'b0;
        return r;
    endfunction

    task automatic supervise(input t_link_event e);
        t_link_result outs[3];
        int           n;
        int           k;
        logic         gave;
        logic         rej;
        logic         up;
        logic         fresh_tm;
        n    = 0;
        gave = 1'b0;
        rej  = 1'b0;
        case (e.ev)
            EV_SEND: begin
                cur_seq      = seq_next;
                seq_next     = seq_next + 16'd1;
                cur_code     = e.code;
                cur_arg      = e.arg;
                cur_stamp    = e.now;
                cur_inflight = 1'b1;
                cur_retries  = '0;
                sent_at      = e.now;
                for (k = 0; k < ((e.code == stop_cmd) ? STOP_REPEATS : 1); k++) begin
                    outs[n] = make_frame(1'b1, TX_KIND_CMD, cur_seq, cur_code, cur_arg,
                                         cur_stamp);
                    n++;
                end
            end
            EV_TICK: begin
                if (cur_inflight && (e.now - sent_at) >= retry_gap_ms) begin
                    if (cur_retries < retry_limit) begin
                        cur_retries = cur_retries + 8'd1;
                        sent_at     = e.now;
                        outs[n] = make_frame(1'b1, TX_KIND_CMD, cur_seq, cur_code, cur_arg,
                                             cur_stamp);
                        n++;
                    end else begin
                        cur_inflight = 1'b0;
                        gave         = 1'b1;
                    end
                end
                if ((e.now - beat_at) >= beat_gap_ms) begin
                    beat_at = e.now;
                    outs[n] = make_frame(1'b1, TX_KIND_HB, seq_next, '0, '0, '0);
                    n++;
                    seq_next = seq_next + 16'd1;
                end
            end
            EV_RX: begin
                if (e.hdr_ok) begin
                    heard_at = e.now;
                    if (e.rx_kind == RX_TELEMETRY && e.len_ok) begin
                        telem_at = e.now;
                    end else if (e.rx_kind == RX_ACK && e.len_ok && cur_inflight &&
                                 e.ack_seq == cur_seq) begin
                        cur_inflight = 1'b0;
                        rej          = !e.accepted;
                    end
                end
            end
            default: begin
            end
        endcase
        if (n == 0) begin
            outs[0] = make_frame(1'b0, TX_KIND_CMD, '0, '0, '0, '0);
            n = 1;
        end
        up       = (heard_at != 0) && ((e.now - heard_at) < stale_ms);
        fresh_tm = (telem_at != 0) && ((e.now - telem_at) < stale_ms);
        for (k = 0; k < n; k++) begin
            outs[k].last        = (k == n - 1);
            outs[k].link_up     = up;
            outs[k].telem_fresh = fresh_tm;
            outs[k].gave_up     = gave;
            outs[k].rejected    = rej;
            frames_due.push_back(outs[k]);
        end
    endtask

    // stimulus helpers
    function automatic t_link_event random_event();
        t_link_event e;
        e.ev       = t_event'($urandom_range(0, 3));
        e.now      = $urandom;
        e.code     = 8'($urandom_range(0, 255));
        e.arg      = $urandom;
        e.rx_kind  = t_rx_kind'($urandom_range(0, 3));
        e.hdr_ok   = 1'($urandom_range(0, 1));
        e.len_ok   = 1'($urandom_range(0, 1));
        e.ack_seq  = 16'($urandom_range(0, 65535));
        e.accepted = 1'($urandom_range(0, 1));
        e.live_ack = 1'b0;
        return e;
    endfunction

    function automatic logic [31:0] pick_dt(input logic [31:0] iv);
        case ($urandom_range(0, 5))
            0:       return 32'd0;
            1:       return iv - 32'd1;
            2:       return iv;
            3:       return iv + 32'd1;
            4:       return $urandom_range(0, 2 * iv);
            default: return $urandom_range(1, 20);
        endcase
    endfunction

    function automatic logic [7:0] pick_code();
        return ($urandom_range(0, 3) == 0) ? stop_cmd : 8'($urandom_range(0, 255));
    endfunction

    task automatic push_event(input t_link_event e);
        events_pending.push_back(e);
        queued_events++;
    endtask

    task automatic tick_after(input logic [31:0] dt);
        t_link_event e;
        e = random_event();
        gen_now = gen_now + dt;
        e.ev  = EV_TICK;
        e.now = gen_now;
        push_event(e);
    endtask

    task automatic command_after(input logic [31:0] dt, input logic [7:0] code,
                                 input logic [31:0] arg);
        t_link_event e;
        e = random_event();
        gen_now = gen_now + dt;
        e.ev   = EV_SEND;
        e.now  = gen_now;
        e.code = code;
        e.arg  = arg;
        push_event(e);
    endtask

    // with live set, seq is an xor mask applied to the sequence in flight at drive time
    task automatic frame_after(input logic [31:0] dt, input t_rx_kind kind,
                               input logic hdr, input logic len, input logic live,
                               input logic [15:0] seq, input logic acc);
        t_link_event e;
        e = random_event();
        gen_now = gen_now + dt;
        e.ev       = EV_RX;
        e.now      = gen_now;
        e.rx_kind  = kind;
        e.hdr_ok   = hdr;
        e.len_ok   = len;
        e.live_ack = live;
        e.ack_seq  = seq;
        e.accepted = acc;
        push_event(e);
    endtask

    task automatic fill_phase(input int count);
        int       start;
        int       reps;
        int       k;
        logic     mostly;
        start = queued_events;
        while (queued_events - start < count) begin
            case ($urandom_range(0, 9))
                0, 1, 2: begin
                    command_after(pick_dt(beat_gap_ms), pick_code(), $urandom);
                    reps = $urandom_range(1, 5);
                    for (k = 0; k < reps; k++) begin
                        tick_after(pick_dt(retry_gap_ms));
                    end
                    if ($urandom_range(0, 1)) begin
                        frame_after(pick_dt(retry_gap_ms), RX_ACK, 1'b1, 1'b1, 1'b1, '0,
                                    1'($urandom_range(0, 1)));
                    end
                end
                3, 4: begin
                    command_after(pick_dt(retry_gap_ms), pick_code(), $urandom);
                    if ($urandom_range(0, 2) == 0) begin
                        tick_after(pick_dt(retry_gap_ms));
                    end
                    frame_after(pick_dt(retry_gap_ms), RX_ACK,
                                1'($urandom_range(0, 5) != 0), 1'($urandom_range(0, 5) != 0),
                                1'b1,
                                ($urandom_range(0, 3) == 0) ?
                                    16'(1 << $urandom_range(0, 15)) : 16'd0,
                                1'($urandom_range(0, 1)));
                end
                5, 6: begin
                    reps = $urandom_range(2, 5);
                    for (k = 0; k < reps; k++) begin
                        mostly = 1'($urandom_range(0, 4) != 0);
                        if ($urandom_range(0, 1)) begin
                            frame_after(pick_dt(stale_ms), t_rx_kind'($urandom_range(0, 3)),
                                        mostly, 1'($urandom_range(0, 4) != 0), 1'b0,
                                        16'($urandom_range(0, 65535)),
                                        1'($urandom_range(0, 1)));
                        end else begin
                            tick_after(pick_dt(stale_ms));
                        end
                    end
                end
                7: begin
                    reps = $urandom_range(2, 4);
                    for (k = 0; k < reps; k++) begin
                        tick_after(pick_dt(beat_gap_ms));
                    end
                end
                8: begin
                    push_event(random_event());
                end
                default: begin
                    gen_now = $urandom_range(0, 1) ? $urandom :
                              32'hFFFF_FFFF - $urandom_range(0, 300);
                    tick_after(32'd0);
                end
            endcase
        end
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            CFG_RETRY_INTERVAL: retry_gap_ms = val;
            CFG_MAX_RETRIES:    retry_limit  = val[7:0];
            CFG_LINK_TIMEOUT:   stale_ms     = val;
            CFG_HB_INTERVAL:    beat_gap_ms  = val;
            CFG_STOP_CODE:      stop_cmd     = val[7:0];
            default: begin
            end
        endcase
        cfg_writes++;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        do @(posedge clk);
        while (events_pending.size() != 0 || s_tvalid || frames_due.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic check_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] got_v);
        if (got_v !== exp_v) begin
            err_cnt++;
            $display("%0t ns: %s mismatch, expected %h, actual %h", $time, name, exp_v, got_v);
        end
    endtask

    // event driver: bursts with random gaps
    always @(negedge clk) begin
        if (!rst_n) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || in_fire) begin
            if (gap_left > 0) begin
                gap_left--;
                s_tvalid <= 1'b0;
            end else if (events_pending.size() > 0) begin
                on_wire = events_pending.pop_front();
                if (on_wire.live_ack) begin
                    on_wire.ack_seq = on_wire.ack_seq ^ cur_seq;
                end
                s_tdata  <= {3'b000, on_wire.accepted, on_wire.ack_seq, on_wire.len_ok,
                             on_wire.hdr_ok, on_wire.rx_kind, on_wire.arg, on_wire.code,
                             on_wire.now};
                s_tuser  <= on_wire.ev;
                s_tvalid <= 1'b1;
                if (burst_left > 0) begin
                    burst_left--;
                end
                if (burst_left == 0) begin
                    burst_left = $urandom_range(1, 12);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    always @(posedge clk) begin
        in_fire <= rst_n && s_tvalid && s_tready;
        if (rst_n && s_tvalid && s_tready) begin
            supervise(on_wire);
            events_in++;
        end
    end

    // result sink with its own stall pattern
    always @(negedge clk) begin
        if (sink_left == 0) begin
            sink_mode   = 2'($urandom_range(0, 2));
            sink_left   = $urandom_range(20, 60);
            sink_period = $urandom_range(2, 4);
            sink_step   = 0;
        end else begin
            sink_left--;
        end
        case (sink_mode)
            SINK_FREE:   m_tready <= 1'b1;
            SINK_RANDOM: m_tready <= ($urandom_range(0, 9) > 2);
            default: begin
                m_tready <= (sink_step == 0);
                sink_step = (sink_step + 1) % sink_period;
            end
        endcase
    end

    always @(posedge clk) begin
        if (rst_n && m_tvalid && m_tready) begin
            seen.tx_valid    = m_tuser[0];
            seen.tx_kind     = m_tuser[1];
            seen.seq         = m_tdata[15:0];
            seen.code        = m_tdata[23:16];
            seen.arg         = m_tdata[55:24];
            seen.stamp       = m_tdata[87:56];
            seen.link_up     = m_tdata[88];
            seen.telem_fresh = m_tdata[89];
            seen.gave_up     = m_tdata[90];
            seen.rejected    = m_tdata[91];
            seen.last        = m_tlast;
            if (frames_due.size() == 0) begin
                err_cnt++;
                $display("%0t ns: unexpected result transfer, expected none, actual %h/%h",
                         $time, m_tuser, m_tdata);
            end else begin
                want = frames_due.pop_front();
                check_field("tx_valid", want.tx_valid, seen.tx_valid);
                check_field("tx_kind", want.tx_kind, seen.tx_kind);
                check_field("tx_seq", want.seq, seen.seq);
                check_field("tx_code", want.code, seen.code);
                check_field("tx_arg", want.arg, seen.arg);
                check_field("tx_stamp", want.stamp, seen.stamp);
                check_field("tlast", want.last, seen.last);
                check_field("link_up", want.link_up, seen.link_up);
                check_field("telemetry_fresh", want.telem_fresh, seen.telem_fresh);
                check_field("gave_up", want.gave_up, seen.gave_up);
                check_field("rejected", want.rejected, seen.rejected);
                if (want.tx_valid) begin
                    frames_out++;
                end
                if (want.last && want.gave_up) begin
                    drops_seen++;
                end
                if (want.last && want.rejected) begin
                    rejects_seen++;
                end
            end
            results_out++;
        end
    end

    // watchdog on any transfer
    always @(posedge clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t ns: no transfer for %0d cycles, %0d results outstanding",
                     $time, quiet_cycles, frames_due.size());
            $display("TEST FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        t_link_event e;
        int          ph;

        // time zero telemetry counts as never heard
        frame_after(32'd0, RX_TELEMETRY, 1'b1, 1'b1, 1'b0, 16'hFFFF, 1'b1);
        tick_after(32'd0);
        e = random_event();
        e.ev       = EV_NONE;
        e.now      = '1;
        e.code     = '1;
        e.arg      = '1;
        e.rx_kind  = RX_RESERVED;
        e.hdr_ok   = 1'b1;
        e.len_ok   = 1'b1;
        e.ack_seq  = '1;
        e.accepted = 1'b1;
        push_event(e);
        command_after(32'd10, 8'hFF, 32'hFFFF_FFFF);
        command_after(32'd10, RST_STOP_CODE, 32'h0);
        // retry chain up to the limit, drop together with a heartbeat
        tick_after(32'd100);
        tick_after(32'd99);
        tick_after(32'd101);
        tick_after(32'd100);
        tick_after(32'd100);
        frame_after(32'd10, RX_ACK, 1'b1, 1'b1, 1'b1, 16'h0000, 1'b1);
        command_after(32'd170, 8'h5A, $urandom);
        // resend ahead of heartbeat
        tick_after(32'd400);
        frame_after(32'd10, RX_ACK, 1'b0, 1'b1, 1'b1, 16'h0000, 1'b0);
        frame_after(32'd10, RX_ACK, 1'b1, 1'b0, 1'b1, 16'h0000, 1'b0);
        frame_after(32'd10, RX_ACK, 1'b1, 1'b1, 1'b1, 16'h0001, 1'b0);
        frame_after(32'd10, RX_ACK, 1'b1, 1'b1, 1'b1, 16'h0000, 1'b0);
        command_after(32'd10, 8'h33, $urandom);
        frame_after(32'd5, RX_ACK, 1'b1, 1'b1, 1'b1, 16'h0000, 1'b1);
        frame_after(32'd5, RX_OTHER, 1'b1, 1'b1, 1'b0, 16'h0000, 1'b0);
        frame_after(32'd5, RX_RESERVED, 1'b1, 1'b1, 1'b0, 16'h0000, 1'b0);
        frame_after(32'd5, RX_TELEMETRY, 1'b1, 1'b0, 1'b0, 16'h0000, 1'b0);
        // telemetry age right at the timeout boundary
        frame_after(32'd5, RX_TELEMETRY, 1'b1, 1'b1, 1'b0, 16'h0000, 1'b0);
        tick_after(32'd999);
        tick_after(32'd1);
        // time wraps between issue and resend
        gen_now = 32'hFFFF_FFF0;
        command_after(32'd15, 8'h01, $urandom);
        tick_after(32'd100);

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        fill_phase(ITEMS_PER_PHASE);
        for (ph = 1; ph < PHASES; ph++) begin
            drain();
            case (ph)
                1: begin
                    write_reg(CFG_RETRY_INTERVAL, 16'd1);
                    write_reg(CFG_MAX_RETRIES, 16'd0);
                    write_reg(CFG_LINK_TIMEOUT, 16'd1);
                    write_reg(CFG_HB_INTERVAL, 16'd1);
                    write_reg(CFG_STOP_CODE, 16'd255);
                end
                2: begin
                    write_reg(CFG_RETRY_INTERVAL, 16'hFFFF);
                    write_reg(CFG_MAX_RETRIES, 16'd255);
                    write_reg(CFG_LINK_TIMEOUT, 16'hFFFF);
                    write_reg(CFG_HB_INTERVAL, 16'hFFFF);
                    write_reg(CFG_STOP_CODE, 16'd0);
                end
                3, 4: begin
                    write_reg(CFG_RETRY_INTERVAL, 16'($urandom_range(1, 300)));
                    write_reg(CFG_MAX_RETRIES, 16'($urandom_range(0, 6)));
                    write_reg(CFG_LINK_TIMEOUT, 16'($urandom_range(1, 3000)));
                    write_reg(CFG_HB_INTERVAL, 16'($urandom_range(1, 1500)));
                    write_reg(CFG_STOP_CODE, 16'($urandom_range(0, 255)));
                end
                default: begin
                    write_reg(CFG_RETRY_INTERVAL, 16'($urandom_range(1, 65535)));
                    write_reg(CFG_MAX_RETRIES, 16'($urandom_range(0, 255)));
                    write_reg(CFG_LINK_TIMEOUT, 16'($urandom_range(1, 65535)));
                    write_reg(CFG_HB_INTERVAL, 16'($urandom_range(1, 65535)));
                    write_reg(CFG_STOP_CODE, 16'($urandom_range(0, 255)));
                end
            endcase
            fill_phase(ITEMS_PER_PHASE);
        end
        drain();

        $display("run covered %0d events and %0d result transfers over %0d register settings",
                 events_in, results_out, PHASES);
        $display("frames sent %0d, commands dropped %0d, rejections %0d, register writes %0d",
                 frames_out, drops_seen, rejects_seen, cfg_writes);
        if (err_cnt == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
